// File: rtl/krt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants of the keyed record table
// Table geometry, field widths, command and status codes, sequencer states
// and the write request that the control passes to the entry store.
// ----------------------------------------------------------------------------
package krt_pkg;

  // table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int CMD_W    = 3;
  localparam int KEY_W    = 30;
  localparam int AGE_W    = 7;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  // packed beat widths, rounded up to whole bytes
  localparam int IN_BITS  = CMD_W + KEY_W + AGE_W + KEY_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STATUS_W + SLOT_W + AGE_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // accepted age range
  localparam logic [AGE_W-1:0] AGE_MIN = AGE_W'(1);
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(110);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_DELETE  = 3'd1,
    CMD_LOOKUP  = 3'd2,
    CMD_SET_AGE = 3'd3,
    CMD_SET_KEY = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADAGE  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // write request into the entry store
  typedef struct packed {
    logic             set_vld;
    logic             clr_vld;
    logic             key_we;
    logic             age_we;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } wr_t;

endpackage

// File: rtl/keyed_record_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table: keyed table with free-slot allocation
// Table of records (valid flag, key, age) driven by insert, delete, lookup,
// set-age and set-key commands, one result beat per command.
// ----------------------------------------------------------------------------
// Every command walks the whole table from slot 0 upward through the single
// read port of the entry store, one entry a cycle, with one shared key
// comparator noting the lowest matching slot and the lowest free slot. A
// command passes through an accept cycle, a scan that covers every entry
// and the registered read, and a finish cycle that updates the table and
// loads the result register. The result register is separate from the
// input side, so a new command is taken while an earlier result still
// waits for out_tready; the finish cycle waits only if that register is
// still full. Reset clears the valid flags at once; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module keyed_record_table (
  input  logic                       clk,
  input  logic                       rst_n,
  // input beat: cmd[2:0], key[32:3], age_in[39:33], new_key[69:40]
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [krt_pkg::IN_W-1:0]   in_tdata,
  // result beat: status[2:0], slot[8:3], age_out[15:9]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [krt_pkg::OUT_W-1:0]  out_tdata
);

  krt_pkg::state_t state_r, state_nxt;

  // held command fields
  krt_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [krt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [krt_pkg::AGE_W-1:0] age_r, age_nxt;
  logic [krt_pkg::KEY_W-1:0] nkey_r, nkey_nxt;

  // scan counter and read pipeline
  logic [krt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      pv_r, pv_nxt;
  logic [krt_pkg::IDX_W-1:0] pidx_r, pidx_nxt;

  // scan findings
  logic                      hit_r, hit_nxt;
  logic [krt_pkg::IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [krt_pkg::AGE_W-1:0] hit_age_r, hit_age_nxt;
  logic                      free_r, free_nxt;
  logic [krt_pkg::IDX_W-1:0] free_idx_r, free_idx_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [krt_pkg::OUT_BITS-1:0]  out_data_r, out_data_nxt;

  // store interface
  logic [krt_pkg::IDX_W-1:0] rd_addr;
  logic [krt_pkg::KEY_W-1:0] rd_key;
  logic [krt_pkg::AGE_W-1:0] rd_age;
  logic                      rd_vld;
  krt_pkg::wr_t              wr_req, wr;

  // finish decision
  krt_pkg::status_t          res_status;
  logic [krt_pkg::IDX_W-1:0] res_idx;
  logic [krt_pkg::AGE_W-1:0] res_age;
  logic                      age_ok;
  logic                      out_load;
  logic                      in_acc;
  logic                      key_eq;

  krt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_key  (rd_key),
    .rd_age  (rd_age),
    .rd_vld  (rd_vld)
  );

  assign in_tready  = (state_r == krt_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = krt_pkg::OUT_W'(out_data_r);
  assign rd_addr    = cnt_r[krt_pkg::IDX_W-1:0];
  assign key_eq     = (rd_key == key_r);
  assign age_ok     = (age_r >= krt_pkg::AGE_MIN) && (age_r <= krt_pkg::AGE_MAX);
  assign out_load   = (state_r == krt_pkg::S_FINISH) && (!out_valid_r || out_tready);
  assign wr         = out_load ? wr_req : '0;

  // command outcome and table update, from the scan findings
  always_comb begin
    res_status = krt_pkg::ST_MISSING;
    res_idx    = '0;
    res_age    = '0;
    wr_req     = '0;
    unique case (cmd_r)
      krt_pkg::CMD_INSERT: begin
        if (!free_r) begin
          res_status = krt_pkg::ST_FULL;
        end else if (hit_r) begin
          res_status = krt_pkg::ST_DUP;
        end else if (!age_ok) begin
          res_status = krt_pkg::ST_BADAGE;
        end else begin
          res_status     = krt_pkg::ST_OK;
          res_idx        = free_idx_r;
          res_age        = age_r;
          wr_req.set_vld = 1'b1;
          wr_req.key_we  = 1'b1;
          wr_req.age_we  = 1'b1;
          wr_req.addr    = free_idx_r;
          wr_req.key     = key_r;
          wr_req.age     = age_r;
        end
      end
      krt_pkg::CMD_DELETE: begin
        if (hit_r) begin
          res_status     = krt_pkg::ST_OK;
          res_idx        = hit_idx_r;
          res_age        = hit_age_r;
          wr_req.clr_vld = 1'b1;
          wr_req.addr    = hit_idx_r;
        end
      end
      krt_pkg::CMD_LOOKUP: begin
        if (hit_r) begin
          res_status = krt_pkg::ST_OK;
          res_idx    = hit_idx_r;
          res_age    = hit_age_r;
        end
      end
      krt_pkg::CMD_SET_AGE: begin
        if (hit_r) begin
          if (age_ok) begin
            res_status    = krt_pkg::ST_OK;
            res_idx       = hit_idx_r;
            res_age       = age_r;
            wr_req.age_we = 1'b1;
            wr_req.addr   = hit_idx_r;
            wr_req.age    = age_r;
          end else begin
            res_status = krt_pkg::ST_BADAGE;
          end
        end
      end
      krt_pkg::CMD_SET_KEY: begin
        if (hit_r) begin
          res_status    = krt_pkg::ST_OK;
          res_idx       = hit_idx_r;
          res_age       = hit_age_r;
          wr_req.key_we = 1'b1;
          wr_req.addr   = hit_idx_r;
          wr_req.key    = nkey_r;
        end
      end
      default: ;
    endcase
  end

  // sequencer: next state and register updates
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    age_nxt       = age_r;
    nkey_nxt      = nkey_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = rd_addr;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_age_nxt   = hit_age_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      krt_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt   = krt_pkg::cmd_t'(in_tdata[2:0]);
          key_nxt   = in_tdata[32:3];
          age_nxt   = in_tdata[39:33];
          nkey_nxt  = in_tdata[69:40];
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = krt_pkg::S_SCAN;
        end
      end
      krt_pkg::S_SCAN: begin
        // issue one read a cycle
        if (cnt_r != krt_pkg::CNT_W'(krt_pkg::ENTRIES)) begin
          pv_nxt  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = krt_pkg::S_FINISH;
        end
        // compare the entry read last cycle
        if (pv_r) begin
          if (rd_vld && key_eq && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pidx_r;
            hit_age_nxt = rd_age;
          end
          if (!rd_vld && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pidx_r;
          end
        end
      end
      krt_pkg::S_FINISH: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_age, krt_pkg::SLOT_W'(res_idx), res_status};
          state_nxt     = krt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = krt_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= krt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r        <= pv_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    age_r      <= age_nxt;
    nkey_r     <= nkey_nxt;
    cnt_r      <= cnt_nxt;
    pidx_r     <= pidx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_age_r  <= hit_age_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// File: rtl/krt_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_store: entry storage of the keyed record table
// Key and age memories with one registered read port and one write port,
// plus the per-entry valid flags, which reset clears at once.
// ----------------------------------------------------------------------------
module krt_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [krt_pkg::IDX_W-1:0]  rd_addr,
  input  krt_pkg::wr_t               wr,
  output logic [krt_pkg::KEY_W-1:0]  rd_key,
  output logic [krt_pkg::AGE_W-1:0]  rd_age,
  output logic                       rd_vld
);

  logic [krt_pkg::KEY_W-1:0] key_mem [krt_pkg::ENTRIES];
  logic [krt_pkg::AGE_W-1:0] age_mem [krt_pkg::ENTRIES];
  logic [krt_pkg::ENTRIES-1:0] vld_r;

  logic [krt_pkg::KEY_W-1:0] rd_key_r;
  logic [krt_pkg::AGE_W-1:0] rd_age_r;
  logic                      rd_vld_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[wr.addr] <= wr.key;
    end
    if (wr.age_we) begin
      age_mem[wr.addr] <= wr.age;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_age_r <= age_mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.set_vld) begin
      vld_r[wr.addr] <= 1'b1;
    end else if (wr.clr_vld) begin
      vld_r[wr.addr] <= 1'b0;
    end
  end

  assign rd_key = rd_key_r;
  assign rd_age = rd_age_r;
  assign rd_vld = rd_vld_r;

endmodule
